/* rtl/friend_graph_flood_reach_defines.svh */
// ----------------------------------------------------------------------------
// friend_graph_flood_reach_defines: assertion macros
// Shared assertion wrappers, clocked on clk_i, reported through $error.
// ----------------------------------------------------------------------------
`ifndef FRIEND_GRAPH_FLOOD_REACH_DEFINES_SVH
`define FRIEND_GRAPH_FLOOD_REACH_DEFINES_SVH

// property checked only while out of reset
`define FGFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that also holds while reset is applied
`define FGFR_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/fgfr_pkg.sv */
// ----------------------------------------------------------------------------
// fgfr_pkg: shared types and constants
// Default node count, fixed field widths and the result record.
// ----------------------------------------------------------------------------
package fgfr_pkg;

  // default number of node slots
  localparam int NodesDef = 32;

  // width of a node field on the ports
  localparam int NodeW = 5;

  // one result record, strobe marks the cycle it is on the ports
  typedef struct packed {
    logic             strobe;
    logic [NodeW-1:0] node;
    logic             valid;
    logic             last;
  } fgfr_result_t;

endpackage

/* rtl/fgfr_adj_mem.sv */
// ----------------------------------------------------------------------------
// fgfr_adj_mem: adjacency row memory
// One row per node, one write and one registered read port; a row never
// written since reset reads as zero through a per-row valid flag.
// ----------------------------------------------------------------------------
module fgfr_adj_mem #(
  parameter int NODES = fgfr_pkg::NodesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(NODES)-1:0]   rd_addr_i,
  output logic [NODES-1:0]           rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(NODES)-1:0]   wr_addr_i,
  input  logic [NODES-1:0]           wr_data_i
);
  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] row_valid_q;
  logic [NODES-1:0] rdata_q;
  logic             rvalid_q;

  // row storage and registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[rd_addr_i];
  end

  // per-row written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      rvalid_q <= row_valid_q[rd_addr_i];
    end
  end

  // unwritten rows read as empty
  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/fgfr_stack_mem.sv */
// ----------------------------------------------------------------------------
// fgfr_stack_mem: walk stack memory
// Holds (node, next index to scan) per depth level, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module fgfr_stack_mem #(
  parameter int NODES = fgfr_pkg::NodesDef
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(NODES)-1:0]   wr_addr_i,
  input  logic [$clog2(NODES)-1:0]   wr_node_i,
  input  logic [$clog2(NODES):0]     wr_next_i,
  input  logic [$clog2(NODES)-1:0]   rd_addr_i,
  output logic [$clog2(NODES)-1:0]   rd_node_o,
  output logic [$clog2(NODES):0]     rd_next_o
);
  localparam int NW = $clog2(NODES);
  localparam int CW = NW + 1;

  logic [NW+CW-1:0] mem [NODES];
  logic [NW+CW-1:0] rdata_q;

  // entry storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_node_i, wr_next_i};
    end
    rdata_q <= mem[rd_addr_i];
  end

  assign rd_node_o = rdata_q[NW+CW-1:CW];
  assign rd_next_o = rdata_q[CW-1:0];

endmodule

/* rtl/fgfr_ctrl.sv */
// ----------------------------------------------------------------------------
// fgfr_ctrl: command sequencer
// Runs edge inserts as read-modify-write of two adjacency rows and the
// depth-first walk over the adjacency and stack memories.
// ----------------------------------------------------------------------------
`include "friend_graph_flood_reach_defines.svh"

module fgfr_ctrl #(
  parameter int NODES = fgfr_pkg::NodesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode_i,
  input  logic [fgfr_pkg::NodeW-1:0]    node_a_i,
  input  logic [fgfr_pkg::NodeW-1:0]    node_b_i,
  output fgfr_pkg::fgfr_result_t        res_o,
  output logic [$clog2(NODES)-1:0]      adj_rd_addr_o,
  input  logic [NODES-1:0]              adj_rd_data_i,
  output logic                          adj_we_o,
  output logic [$clog2(NODES)-1:0]      adj_wa_o,
  output logic [NODES-1:0]              adj_wd_o,
  output logic                          stk_we_o,
  output logic [$clog2(NODES)-1:0]      stk_wa_o,
  output logic [$clog2(NODES)-1:0]      stk_wnode_o,
  output logic [$clog2(NODES):0]        stk_wnext_o,
  output logic [$clog2(NODES)-1:0]      stk_ra_o,
  input  logic [$clog2(NODES)-1:0]      stk_rd_node_i,
  input  logic [$clog2(NODES):0]        stk_rd_next_i
);
  import fgfr_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int CW = NW + 1;
  localparam logic [NODES-1:0] One = NODES'(1);

  typedef enum logic [2:0] {
    IDLE,
    ADD_WA,
    ADD_WB,
    SCAN,
    POP
  } state_e;

  state_e         state_q, state_d;
  logic [NW-1:0]  cur_q, cur_d;
  logic [NW-1:0]  oth_q, oth_d;
  logic [CW-1:0]  next_q, next_d;
  logic [NW-1:0]  sp_q, sp_d;
  logic [NODES-1:0] visited_q, visited_d;
  logic [NW-1:0]  pend_node_q, pend_node_d;
  logic           pend_have_q, pend_have_d;
  fgfr_result_t   res_q, res_d;

  logic           a_ok, b_ok;
  logic [NODES-1:0] ge_mask;
  logic [NODES-1:0] cand;
  logic           found;
  logic [NW-1:0]  idx;
  logic           push;

  // port range checks
  assign a_ok = (32'(node_a_i) < 32'(NODES));
  assign b_ok = (32'(node_b_i) < 32'(NODES));

  // neighbors at or above the scan position that are not yet visited
  always_comb begin
    for (int k = 0; k < NODES; k++) begin
      ge_mask[k] = (CW'(k) >= next_q);
    end
  end
  assign cand = adj_rd_data_i & ~visited_q & ge_mask;

  // lowest candidate index
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int k = NODES - 1; k >= 0; k--) begin
      if (cand[k]) begin
        found = 1'b1;
        idx   = NW'(k);
      end
    end
  end

  assign push = (state_q == SCAN) && found && (sp_q != NW'(NODES - 1));

  // next-state and memory port logic
  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    oth_d         = oth_q;
    next_d        = next_q;
    sp_d          = sp_q;
    visited_d     = visited_q;
    pend_node_d   = pend_node_q;
    pend_have_d   = pend_have_q;
    res_d         = '0;
    adj_rd_addr_o = cur_q;
    adj_we_o      = 1'b0;
    adj_wa_o      = cur_q;
    adj_wd_o      = adj_rd_data_i;
    stk_we_o      = 1'b0;
    stk_wa_o      = sp_q;
    stk_wnode_o   = cur_q;
    stk_wnext_o   = CW'(idx) + 1'b1;
    stk_ra_o      = sp_q - 1'b1;

    unique case (state_q)
      IDLE: begin
        adj_rd_addr_o = NW'(node_a_i);
        if (start) begin
          if (!mode_i) begin
            if (a_ok && b_ok) begin
              cur_d   = NW'(node_a_i);
              oth_d   = NW'(node_b_i);
              state_d = ADD_WA;
            end
          end else if (a_ok) begin
            visited_d   = One << NW'(node_a_i);
            cur_d       = NW'(node_a_i);
            next_d      = '0;
            sp_d        = '0;
            pend_have_d = 1'b0;
            state_d     = SCAN;
          end else begin
            // source out of range: single empty result
            res_d.strobe = 1'b1;
            res_d.last   = 1'b1;
          end
        end
      end

      // row a is on the read port; row b read in the same cycle sees the
      // old row, which gives the same final row when both ends match
      ADD_WA: begin
        adj_we_o      = 1'b1;
        adj_wa_o      = cur_q;
        adj_wd_o      = adj_rd_data_i | (One << oth_q);
        adj_rd_addr_o = oth_q;
        state_d       = ADD_WB;
      end

      ADD_WB: begin
        adj_we_o = 1'b1;
        adj_wa_o = oth_q;
        adj_wd_o = adj_rd_data_i | (One << cur_q);
        state_d  = IDLE;
      end

      SCAN: begin
        if (push) begin
          // descend: save parent with resume index, fetch child row
          stk_we_o      = 1'b1;
          sp_d          = sp_q + 1'b1;
          visited_d     = visited_q | (One << idx);
          cur_d         = idx;
          next_d        = '0;
          adj_rd_addr_o = idx;
          if (pend_have_q) begin
            res_d.strobe = 1'b1;
            res_d.node   = NodeW'(pend_node_q);
            res_d.valid  = 1'b1;
          end
          pend_node_d = idx;
          pend_have_d = 1'b1;
        end else if (sp_q != '0) begin
          // backtrack: parent entry read this cycle
          sp_d    = sp_q - 1'b1;
          state_d = POP;
        end else begin
          // walk done: flush held result as the last one
          res_d.strobe = 1'b1;
          res_d.last   = 1'b1;
          res_d.valid  = pend_have_q;
          res_d.node   = pend_have_q ? NodeW'(pend_node_q) : '0;
          pend_have_d  = 1'b0;
          state_d      = IDLE;
        end
      end

      POP: begin
        cur_d         = stk_rd_node_i;
        next_d        = stk_rd_next_i;
        adj_rd_addr_o = stk_rd_node_i;
        state_d       = SCAN;
      end

      default: state_d = IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cur_q       <= '0;
      oth_q       <= '0;
      next_q      <= '0;
      sp_q        <= '0;
      visited_q   <= '0;
      pend_node_q <= '0;
      pend_have_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      oth_q       <= oth_d;
      next_q      <= next_d;
      sp_q        <= sp_d;
      visited_q   <= visited_d;
      pend_node_q <= pend_node_d;
      pend_have_q <= pend_have_d;
      res_q       <= res_d;
    end
  end

  assign busy  = (state_q != IDLE);
  assign res_o = res_q;

  // checks
  `FGFR_ASSERT(a_mid_in_walk, (res_q.strobe && !res_q.last) |-> (state_q == SCAN), "non-final result outside walk")
  `FGFR_ASSERT_NR(a_empty_is_last, (res_q.strobe && !res_q.valid) |-> res_q.last, "empty result not last")
  `FGFR_ASSERT(a_cur_visited, (state_q == SCAN) |-> visited_q[cur_q], "scanned node not visited")
  `FGFR_ASSERT(a_push_depth, push |=> (sp_q == $past(sp_q) + 1'b1), "stack depth not advanced")
  `FGFR_ASSERT(a_idle_clean, (state_q == IDLE) |-> !pend_have_q, "held result left in idle")

endmodule

/* rtl/friend_graph_flood_reach.sv */
// ----------------------------------------------------------------------------
// friend_graph_flood_reach: depth-first reach over a friendship graph
// Symmetric bit adjacency memory with edge insert and depth-first flood
// from a source node, reporting reached nodes in preorder.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when               payload
//  command   in         start && !busy              mode_i, node_a_i, node_b_i
//  result    out        result_valid_o (1 cycle)    reached_node_o,
//                                                   reached_valid_o, last_o
//
//  add: busy while row a and then row b are rewritten.
//  flood: busy until the walk ends; each descent is a SCAN step and each
//  backtrack a SCAN then a POP step, set by the registered reads of
//  the adjacency and stack memories. Each result is delayed by one descent
//  so the final one carries last; the final strobe shows as busy drops.
//  reset clears the adjacency memory at once through per-row flags.
//  the receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module friend_graph_flood_reach #(
  parameter int NODES = fgfr_pkg::NodesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [fgfr_pkg::NodeW-1:0]  node_a_i,
  input  logic [fgfr_pkg::NodeW-1:0]  node_b_i,
  output logic                        result_valid_o,
  output logic [fgfr_pkg::NodeW-1:0]  reached_node_o,
  output logic                        reached_valid_o,
  output logic                        last_o
);
  import fgfr_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int CW = NW + 1;

  fgfr_result_t   res;
  logic [NW-1:0]  adj_rd_addr;
  logic [NODES-1:0] adj_rd_data;
  logic           adj_we;
  logic [NW-1:0]  adj_wa;
  logic [NODES-1:0] adj_wd;
  logic           stk_we;
  logic [NW-1:0]  stk_wa;
  logic [NW-1:0]  stk_wnode;
  logic [CW-1:0]  stk_wnext;
  logic [NW-1:0]  stk_ra;
  logic [NW-1:0]  stk_rd_node;
  logic [CW-1:0]  stk_rd_next;

  // sequencer
  fgfr_ctrl #(
    .NODES(NODES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .res_o         (res),
    .adj_rd_addr_o (adj_rd_addr),
    .adj_rd_data_i (adj_rd_data),
    .adj_we_o      (adj_we),
    .adj_wa_o      (adj_wa),
    .adj_wd_o      (adj_wd),
    .stk_we_o      (stk_we),
    .stk_wa_o      (stk_wa),
    .stk_wnode_o   (stk_wnode),
    .stk_wnext_o   (stk_wnext),
    .stk_ra_o      (stk_ra),
    .stk_rd_node_i (stk_rd_node),
    .stk_rd_next_i (stk_rd_next)
  );

  // adjacency rows
  fgfr_adj_mem #(
    .NODES(NODES)
  ) u_adj_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (adj_rd_addr),
    .rd_data_o (adj_rd_data),
    .wr_en_i   (adj_we),
    .wr_addr_i (adj_wa),
    .wr_data_i (adj_wd)
  );

  // walk stack
  fgfr_stack_mem #(
    .NODES(NODES)
  ) u_stack_mem (
    .clk_i     (clk_i),
    .wr_en_i   (stk_we),
    .wr_addr_i (stk_wa),
    .wr_node_i (stk_wnode),
    .wr_next_i (stk_wnext),
    .rd_addr_i (stk_ra),
    .rd_node_o (stk_rd_node),
    .rd_next_o (stk_rd_next)
  );

  // result ports
  assign result_valid_o  = res.strobe;
  assign reached_node_o  = res.node;
  assign reached_valid_o = res.valid;
  assign last_o          = res.last;

endmodule
